FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the rotator RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition holds at every clock edge outside reset
`define AVR_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define AVR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define AVR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define AVR_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define AVR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define AVR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: design/avr_pkg.sv
// ----------------------------------------------------------------------------
// avr_pkg
// Types, constants and tables of the axis vector rotator
// ----------------------------------------------------------------------------
package avr_pkg;

    localparam int COORD_BITS   = 16;
    localparam int ANGLE_BITS   = 16;
    localparam int CORDIC_STEPS = 20;

    // cordic datapath: Q2.30 with guard bits
    localparam int FRAC_BITS = 30;
    localparam int TURN_BITS = 32;
    localparam int CW        = FRAC_BITS + 4;
    localparam int ZW        = FRAC_BITS + 3;
    localparam int PROD_W    = CW + COORD_BITS;
    localparam int SUM_W     = PROD_W + 1;

    // input register, cordic steps, quadrant, multiply, sum and output
    localparam int PIPE_DEPTH = CORDIC_STEPS + 4;
    localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);

    localparam logic [1:0] KIND_X    = 2'd0;
    localparam logic [1:0] KIND_Y    = 2'd1;
    localparam logic [1:0] KIND_Z    = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic [ANGLE_BITS-1:0]        t_angle;
    typedef logic signed [CW-1:0]         t_cw;
    typedef logic signed [ZW-1:0]         t_zw;

    typedef struct packed {
        logic [1:0] kind;
        t_coord     x;
        t_coord     y;
        t_coord     z;
    } t_point;

    typedef struct packed {
        logic [1:0] quad;
        t_cw        cx;
        t_cw        cy;
        t_point     pt;
    } t_sincos;

    // 0.6072529350 in Q2.30
    localparam t_cw CORDIC_GAIN = 34'sd652032874;

    // arctangent of 2^-i, 2^32 units per turn
    localparam t_zw ATAN_TABLE [CORDIC_STEPS] = '{
        33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
        33'sd42667331,  33'sd21354465,  33'sd10679838,  33'sd5340245,
        33'sd2670163,   33'sd1335087,   33'sd667544,    33'sd333772,
        33'sd166886,    33'sd83443,     33'sd41722,     33'sd20861,
        33'sd10430,     33'sd5215,      33'sd2608,      33'sd1304
    };

endpackage

FILE: design/avr_in_if.sv
// ----------------------------------------------------------------------------
// avr_in_if
// Input channel of the rotator: axis, point and angle
// ----------------------------------------------------------------------------
interface avr_in_if import avr_pkg::*; ();

    logic       valid;
    logic       ready;
    logic [1:0] kind;
    t_coord     in_x;
    t_coord     in_y;
    t_coord     in_z;
    t_angle     turn_angle;

    modport source (
        output valid, kind, in_x, in_y, in_z, turn_angle,
        input  ready
    );

    modport sink (
        input  valid, kind, in_x, in_y, in_z, turn_angle,
        output ready
    );

endinterface

FILE: design/avr_out_if.sv
// ----------------------------------------------------------------------------
// avr_out_if
// Output channel of the rotator: rotated point
// ----------------------------------------------------------------------------
interface avr_out_if import avr_pkg::*; ();

    logic   valid;
    logic   ready;
    t_coord out_x;
    t_coord out_y;
    t_coord out_z;

    modport source (
        output valid, out_x, out_y, out_z,
        input  ready
    );

    modport sink (
        input  valid, out_x, out_y, out_z,
        output ready
    );

endinterface

FILE: design/avr_cordic.sv
// ----------------------------------------------------------------------------
// avr_cordic
// Pipelined rotation-mode cordic, one micro-rotation per stage
// ----------------------------------------------------------------------------
module avr_cordic import avr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_valid,
    input  t_point  i_point,
    input  t_angle  i_angle,
    output logic    o_valid,
    output t_sincos o_sc
);

    logic [CORDIC_STEPS:0] r_valid;
    t_cw                   r_x    [CORDIC_STEPS+1];
    t_cw                   r_y    [CORDIC_STEPS+1];
    t_zw                   r_z    [CORDIC_STEPS+1];
    logic [1:0]            r_quad [CORDIC_STEPS+1];
    t_point                r_pt   [CORDIC_STEPS+1];
    logic [TURN_BITS-1:0]  w_turn;

    assign w_turn = {i_angle, {(TURN_BITS-ANGLE_BITS){1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[CORDIC_STEPS-1:0], i_valid};
        end
    end

    // top two bits pick the quadrant, the rest is the first-quadrant angle
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= CORDIC_GAIN;
            r_y[0]    <= '0;
            r_z[0]    <= {{(ZW-FRAC_BITS){1'b0}}, w_turn[FRAC_BITS-1:0]};
            r_quad[0] <= w_turn[TURN_BITS-1 -: 2];
            r_pt[0]   <= i_point;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        t_cw w_dx;
        t_cw w_dy;

        assign w_dx = r_y[i] >>> i;
        assign w_dy = r_x[i] >>> i;

        // zero residual counts as positive
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[i][ZW-1]) begin
                    r_x[i+1] <= r_x[i] - w_dx;
                    r_y[i+1] <= r_y[i] + w_dy;
                    r_z[i+1] <= r_z[i] - ATAN_TABLE[i];
                end else begin
                    r_x[i+1] <= r_x[i] + w_dx;
                    r_y[i+1] <= r_y[i] - w_dy;
                    r_z[i+1] <= r_z[i] + ATAN_TABLE[i];
                end
                r_quad[i+1] <= r_quad[i];
                r_pt[i+1]   <= r_pt[i];
            end
        end
    end

    assign o_valid    = r_valid[CORDIC_STEPS];
    assign o_sc.quad  = r_quad[CORDIC_STEPS];
    assign o_sc.cx    = r_x[CORDIC_STEPS];
    assign o_sc.cy    = r_y[CORDIC_STEPS];
    assign o_sc.pt    = r_pt[CORDIC_STEPS];

endmodule

FILE: design/avr_rotate.sv
// ----------------------------------------------------------------------------
// avr_rotate
// Quadrant fold, plane rotation products, rounding and saturation
// ----------------------------------------------------------------------------
module avr_rotate import avr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_valid,
    input  t_sincos i_sc,
    output logic    o_valid,
    output t_coord  o_x,
    output t_coord  o_y,
    output t_coord  o_z
);

    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [SUM_W-1:0]  t_sum;

    localparam t_sum ROUND_HALF = t_sum'(1) <<< (FRAC_BITS - 1);
    localparam t_sum SAT_HI     = (t_sum'(1) <<< (COORD_BITS - 1)) - t_sum'(1);
    localparam t_sum SAT_LO     = -(t_sum'(1) <<< (COORD_BITS - 1));

    function automatic t_coord sat_coord(input t_sum v);
        t_coord r;
        if (v > SAT_HI) begin
            r = SAT_HI[COORD_BITS-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[COORD_BITS-1:0];
        end else begin
            r = v[COORD_BITS-1:0];
        end
        return r;
    endfunction

    logic [2:0] r_valid;

    // stage a: folded sine and cosine
    t_cw    r_c;
    t_cw    r_s;
    t_point r_pt_a;
    t_cw    n_c;
    t_cw    n_s;

    // stage b: products of the rotated plane (u, v)
    t_prod  r_cu;
    t_prod  r_sv;
    t_prod  r_su;
    t_prod  r_cv;
    t_point r_pt_b;
    t_coord w_u;
    t_coord w_v;

    // stage c: output register
    t_coord r_ox;
    t_coord r_oy;
    t_coord r_oz;
    t_sum   w_u_sum;
    t_sum   w_v_sum;
    t_coord w_u_rot;
    t_coord w_v_rot;
    t_coord n_ox;
    t_coord n_oy;
    t_coord n_oz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    always_comb begin
        unique case (i_sc.quad)
            QUAD_0: begin
                n_c = i_sc.cx;
                n_s = i_sc.cy;
            end
            QUAD_1: begin
                n_c = -i_sc.cy;
                n_s = i_sc.cx;
            end
            QUAD_2: begin
                n_c = -i_sc.cx;
                n_s = -i_sc.cy;
            end
            QUAD_3: begin
                n_c = i_sc.cy;
                n_s = -i_sc.cx;
            end
            default: begin
                n_c = i_sc.cx;
                n_s = i_sc.cy;
            end
        endcase
    end

    // every axis is u' = c*u - s*v, v' = s*u + c*v on its own plane
    always_comb begin
        case (r_pt_a.kind)
            KIND_X: begin
                w_u = r_pt_a.y;
                w_v = r_pt_a.z;
            end
            KIND_Y: begin
                w_u = r_pt_a.z;
                w_v = r_pt_a.x;
            end
            KIND_Z: begin
                w_u = r_pt_a.x;
                w_v = r_pt_a.y;
            end
            default: begin
                w_u = '0;
                w_v = '0;
            end
        endcase
    end

    assign w_u_sum = (t_sum'(r_cu) - t_sum'(r_sv) + ROUND_HALF) >>> FRAC_BITS;
    assign w_v_sum = (t_sum'(r_su) + t_sum'(r_cv) + ROUND_HALF) >>> FRAC_BITS;
    assign w_u_rot = sat_coord(w_u_sum);
    assign w_v_rot = sat_coord(w_v_sum);

    always_comb begin
        n_ox = r_pt_b.x;
        n_oy = r_pt_b.y;
        n_oz = r_pt_b.z;
        case (r_pt_b.kind)
            KIND_X: begin
                n_oy = w_u_rot;
                n_oz = w_v_rot;
            end
            KIND_Y: begin
                n_oz = w_u_rot;
                n_ox = w_v_rot;
            end
            KIND_Z: begin
                n_ox = w_u_rot;
                n_oy = w_v_rot;
            end
            default: begin
                n_ox = r_pt_b.x;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c    <= n_c;
            r_s    <= n_s;
            r_pt_a <= i_sc.pt;

            r_cu   <= t_prod'(r_c) * t_prod'(w_u);
            r_sv   <= t_prod'(r_s) * t_prod'(w_v);
            r_su   <= t_prod'(r_s) * t_prod'(w_u);
            r_cv   <= t_prod'(r_c) * t_prod'(w_v);
            r_pt_b <= r_pt_a;

            r_ox   <= n_ox;
            r_oy   <= n_oy;
            r_oz   <= n_oz;
        end
    end

    assign o_valid = r_valid[2];
    assign o_x     = r_ox;
    assign o_y     = r_oy;
    assign o_z     = r_oz;

endmodule

FILE: design/axis_vector_rotator_unit.sv
// ----------------------------------------------------------------------------
// axis_vector_rotator_unit
// Rotates a Q8.8 point about the X, Y or Z axis by a binary angle
// ----------------------------------------------------------------------------
// channel  | dir | payload                                | handshake
// i_in     | in  | kind, in_x, in_y, in_z, turn_angle     | valid / ready
// o_out    | out | out_x, out_y, out_z                    | valid / ready
//
// one point per cycle; each point passes from transfer in to result through
// the input register, the 20-stage cordic, and the quadrant, multiply and sum stages
// the whole pipeline advances together; it halts only while a result sits
// in the output register and the sink is not ready, and nothing is dropped
// reset empties the pipeline, no clearing pass
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module axis_vector_rotator_unit import avr_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    avr_in_if.sink     i_in,
    avr_out_if.source  o_out
);

    logic       w_en;
    logic       w_in_xfer;
    logic       w_out_xfer;
    t_point     w_point;
    logic       w_sc_valid;
    t_sincos    w_sc;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    assign w_en       = !o_out.valid || o_out.ready;
    assign i_in.ready = w_en;
    assign w_in_xfer  = i_in.valid && i_in.ready;
    assign w_out_xfer = o_out.valid && o_out.ready;

    assign w_point.kind = i_in.kind;
    assign w_point.x    = i_in.in_x;
    assign w_point.y    = i_in.in_y;
    assign w_point.z    = i_in.in_z;

    avr_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in.valid),
        .i_point (w_point),
        .i_angle (i_in.turn_angle),
        .o_valid (w_sc_valid),
        .o_sc    (w_sc)
    );

    avr_rotate u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sc_valid),
        .i_sc    (w_sc),
        .o_valid (o_out.valid),
        .o_x     (o_out.out_x),
        .o_y     (o_out.out_y),
        .o_z     (o_out.out_z)
    );

    // points in flight
    always_comb begin
        n_count = r_count;
        if (w_in_xfer && !w_out_xfer) begin
            n_count = r_count + CNT_W'(1);
        end else if (!w_in_xfer && w_out_xfer) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    `AVR_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(PIPE_DEPTH))
    `AVR_ASSERT_IMPL(a_no_phantom, i_clk, i_rst_n, o_out.valid, r_count != '0)
    `AVR_ASSERT_IMPL(a_stall_cause, i_clk, i_rst_n, !i_in.ready, o_out.valid)
    `AVR_ASSERT_NEXT(a_empty_stays, i_clk, i_rst_n, r_count == '0 && !w_in_xfer, !o_out.valid)

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the axis vector rotator: a bit-exact cordic
// predictor works out each rotated point at the input transfer and a
// scoreboard matches results in order, under random idling on both sides
// ----------------------------------------------------------------------------
module testbench import avr_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         HOLD_CYCLES  = 400;
    localparam int         BLOCKS       = 20;
    localparam int         BLOCK_POINTS = 94;
    localparam longint     GAIN_Q30     = 64'sd652032874;
    localparam longint     ARCTAN_TURNS [CORDIC_STEPS] = '{
        536870912, 316933406, 167458907, 85004756, 42667331,
        21354465,  10679838,  5340245,   2670163,  1335087,
        667544,    333772,    166886,    83443,    41722,
        20861,     10430,     5215,      2608,     1304
    };

    typedef struct {
        t_coord x;
        t_coord y;
        t_coord z;
    } rotated_point_t;

    class rotation_board;
        rotated_point_t expected_points[$];
        int unsigned    errors;

        function new();
            errors = 0;
        endfunction

        // sine and cosine in Q2.30 from the quadrant and a 20-step cordic
        function void cordic_sin_cos(input t_angle ang, output longint c, output longint s);
            bit [31:0] turn32;
            bit [1:0]  quad;
            longint    cx;
            longint    sy;
            longint    resid;
            longint    dx;
            longint    dy;
            turn32 = 32'(ang) << (32 - ANGLE_BITS);
            quad   = turn32[31:30];
            resid  = longint'(turn32 & 32'h3FFF_FFFF);
            cx     = GAIN_Q30;
            sy     = 0;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                dx = sy >>> i;
                dy = cx >>> i;
                // zero residual steps the positive way
                if (resid >= 0) begin
                    cx    = cx - dx;
                    sy    = sy + dy;
                    resid = resid - ARCTAN_TURNS[i];
                end else begin
                    cx    = cx + dx;
                    sy    = sy - dy;
                    resid = resid + ARCTAN_TURNS[i];
                end
            end
            case (quad)
                QUAD_0: begin c = cx;  s = sy;  end
                QUAD_1: begin c = -sy; s = cx;  end
                QUAD_2: begin c = -cx; s = -sy; end
                default: begin c = sy; s = -cx; end
            endcase
        endfunction

        // round half up out of Q30, then clamp to the coordinate range
        function t_coord round_to_coord(input longint acc);
            longint r;
            longint hi;
            longint lo;
            hi = (longint'(1) << (COORD_BITS - 1)) - 1;
            lo = -(longint'(1) << (COORD_BITS - 1));
            r  = (acc + (longint'(1) << 29)) >>> 30;
            if (r > hi) r = hi;
            if (r < lo) r = lo;
            return t_coord'(r);
        endfunction

        function void note_point(input logic [1:0] kind, input t_coord x, input t_coord y,
                                 input t_coord z, input t_angle ang);
            longint         c;
            longint         s;
            longint         px;
            longint         py;
            longint         pz;
            rotated_point_t res;
            cordic_sin_cos(ang, c, s);
            px    = longint'(x);
            py    = longint'(y);
            pz    = longint'(z);
            res.x = x;
            res.y = y;
            res.z = z;
            case (kind)
                KIND_X: begin
                    res.y = round_to_coord(c * py - s * pz);
                    res.z = round_to_coord(s * py + c * pz);
                end
                KIND_Y: begin
                    res.x = round_to_coord(c * px + s * pz);
                    res.z = round_to_coord(c * pz - s * px);
                end
                KIND_Z: begin
                    res.x = round_to_coord(c * px - s * py);
                    res.y = round_to_coord(s * px + c * py);
                end
                default: ;
            endcase
            expected_points.push_back(res);
        endfunction

        function void check_point(input t_coord x, input t_coord y, input t_coord z);
            rotated_point_t exp_pt;
            if (expected_points.size() == 0) begin
                $display("%0t: unexpected result x=%0d y=%0d z=%0d", $time, x, y, z);
                errors++;
                return;
            end
            exp_pt = expected_points.pop_front();
            if (x !== exp_pt.x) begin
                $display("%0t: out_x expected %0d got %0d", $time, exp_pt.x, x);
                errors++;
            end
            if (y !== exp_pt.y) begin
                $display("%0t: out_y expected %0d got %0d", $time, exp_pt.y, y);
                errors++;
            end
            if (z !== exp_pt.z) begin
                $display("%0t: out_z expected %0d got %0d", $time, exp_pt.z, z);
                errors++;
            end
        endfunction

        function int pending_count();
            return expected_points.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    avr_in_if  in_if ();
    avr_out_if out_if ();

    axis_vector_rotator_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    rotation_board board = new();

    bit src_idle;
    bit sink_idle;
    bit hold_off_req;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int unsigned idle_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // offer one point, hold it until the transfer, then maybe go quiet
    task automatic send_point(input logic [1:0] kind, input t_coord x, input t_coord y,
                              input t_coord z, input t_angle ang);
        int unsigned gap;
        in_if.valid      <= 1'b1;
        in_if.kind       <= kind;
        in_if.in_x       <= x;
        in_if.in_y       <= y;
        in_if.in_z       <= z;
        in_if.turn_angle <= ang;
        do @(posedge i_clk); while (!in_if.ready);
        board.note_point(kind, x, y, z, ang);
        gap = 0;
        if (src_idle && $urandom_range(0, 99) >= 65) gap = idle_len();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic t_coord random_coord();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 5) return t_coord'($urandom);
        if (r < 8) return t_coord'(int'($urandom_range(0, 2047)) - 1024);
        if (r == 8) return $urandom_range(0, 1) ? t_coord'(32767) : t_coord'(-32768);
        return t_coord'(int'($urandom_range(0, 4)) - 2);
    endfunction

    task automatic send_random_point();
        int unsigned k;
        logic [1:0]  kind;
        t_angle      ang;
        k = $urandom_range(0, 99);
        if (k < 31)      kind = KIND_X;
        else if (k < 62) kind = KIND_Y;
        else if (k < 93) kind = KIND_Z;
        else             kind = KIND_NONE;
        // near the quadrant boundaries now and then
        if ($urandom_range(0, 4) == 0)
            ang = t_angle'($urandom_range(0, 3) * 16384 + $urandom_range(0, 2) - 1);
        else
            ang = t_angle'($urandom);
        send_point(kind, random_coord(), random_coord(), random_coord(), ang);
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (board.pending_count() != 0) @(posedge i_clk);
    endtask

    // result side: random back-pressure, plus one long hold-off on request
    initial begin
        int unsigned hold_left;
        int unsigned stall_left;
        hold_left    = 0;
        stall_left   = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                out_if.ready <= 1'b0;
            end else if (!sink_idle) begin
                out_if.ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else if ($urandom_range(0, 99) < 25) begin
                stall_left = idle_len() - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            board.check_point(out_if.out_x, out_if.out_y, out_if.out_z);
    end

    initial begin
        #2_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    initial begin
        src_idle         = 1'b0;
        sink_idle        = 1'b1;
        hold_off_req     = 1'b0;
        i_rst_n          <= 1'b0;
        in_if.valid      <= 1'b0;
        in_if.kind       <= KIND_X;
        in_if.in_x       <= '0;
        in_if.in_y       <= '0;
        in_if.in_z       <= '0;
        in_if.turn_angle <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // every axis, quadrant boundaries, saturation and the pass-through code
        send_point(KIND_X,    256,    512,    -768,   0);
        send_point(KIND_Y,    256,    512,    -768,   0);
        send_point(KIND_Z,    256,    512,    -768,   0);
        send_point(KIND_NONE, 256,    512,    -768,   8192);
        send_point(KIND_X,    256,    512,    -768,   16384);
        send_point(KIND_Y,    256,    512,    -768,   32768);
        send_point(KIND_Z,    256,    512,    -768,   49152);
        send_point(KIND_Z,    256,    512,    -768,   65535);
        send_point(KIND_X,    1000,   -2000,  3000,   1);
        send_point(KIND_Y,    1000,   -2000,  3000,   8192);
        send_point(KIND_Z,    32767,  32767,  32767,  8192);
        send_point(KIND_Z,    -32768, -32768, -32768, 8192);
        send_point(KIND_X,    -32768, -32768, -32768, 32768);
        send_point(KIND_Y,    32767,  -32768, 32767,  24576);
        send_point(KIND_NONE, 32767,  -32768, -1,     65535);
        send_point(KIND_NONE, -32768, 32767,  0,      0);
        send_point(KIND_Z,    0,      0,      0,      40000);
        send_point(KIND_X,    -1,     -1,     -1,     12345);
        send_point(KIND_Y,    1,      1,      1,      16383);
        send_point(KIND_Z,    20000,  -20000, 12000,  5461);
        send_point(KIND_Z,    32767,  0,      0,      16384);
        send_point(KIND_Y,    -32768, 0,      32767,  49152);

        for (int blk = 0; blk < BLOCKS; blk++) begin
            src_idle  = ($urandom_range(0, 3) != 0);
            sink_idle = ($urandom_range(0, 3) != 0);
            if (blk == 0) begin
                src_idle  = 1'b0;
                sink_idle = 1'b0;
            end
            // sink stalls for a long stretch while points keep coming
            if (blk == 4) begin
                src_idle     = 1'b0;
                hold_off_req = 1'b1;
            end
            if (blk == 9) wait_drained();
            for (int n = 0; n < BLOCK_POINTS; n++) send_random_point();
        end

        wait_drained();
        repeat (PIPE_DEPTH + 10) @(posedge i_clk);
        if (board.errors == 0 && board.pending_count() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
